// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor writer package
// Shared constants, codes and the result record of the console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

	// Default screen geometry.
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Fixed widths of the result fields.
	localparam int OP_W       = 2;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int CELL_W     = 16;
	localparam int BYTE_W     = 8;

	// Tab stops fall on multiples of this.
	localparam int TAB_STEP = 8;

	// Character codes with special meaning.
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_LAST    = 8'h7F;

	// Item kinds carried on the input tuser.
	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_SET = 1'b1;

	// Write operation of a result.
	typedef enum logic [OP_W-1:0] {
		OP_NONE = 2'd0,
		OP_CELL = 2'd1,
		OP_FILL = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col_first;
		logic [COL_OUT_W-1:0] col_last;
		logic [CELL_W-1:0]    cell_res;
		logic [COL_OUT_W-1:0] cursor_col;
		logic [ROW_OUT_W-1:0] cursor_row;
	} result_t;

endpackage

// ===== rtl/tcc_step.sv =====
// ----------------------------------------------------------------------------
// Text console cursor step
// Works out the write and the new cursor position for one registered item.
// ----------------------------------------------------------------------------
module tcc_step #(
	parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcc_pkg::ROWS_DEF,
	parameter int COL_W   = $clog2(COLUMNS),
	parameter int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                       cmd,
	input  logic [tcc_pkg::BYTE_W-1:0] char_code,
	input  logic [tcc_pkg::BYTE_W-1:0] attr,
	input  logic [tcc_pkg::BYTE_W-1:0] new_col,
	input  logic [tcc_pkg::BYTE_W-1:0] new_row,
	input  logic [COL_W-1:0]           col,
	input  logic [ROW_W-1:0]           row,
	output logic [COL_W-1:0]           col_next,
	output logic [ROW_W-1:0]           row_next,
	output tcc_pkg::result_t           res
);
	import tcc_pkg::*;

	localparam int CW1 = COL_W + 1;
	localparam int BW1 = BYTE_W + 1;

	logic [ROW_W-1:0] row_inc;
	logic [CW1-1:0]   col_inc;
	logic [CW1-1:0]   tab_col;
	logic             printable;

	always_comb begin
		row_inc   = (row == ROW_W'(ROWS - 1)) ? '0 : row + ROW_W'(1);
		col_inc   = {1'b0, col} + CW1'(1);
		tab_col   = ({1'b0, col} + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);
		printable = (char_code >= CH_SPACE) && (char_code <= CH_LAST);

		col_next      = col;
		row_next      = row;
		res.op        = OP_NONE;
		res.row       = '0;
		res.col_first = '0;
		res.col_last  = '0;
		res.cell_res  = '0;

		if (cmd == CMD_SET) begin
			// Each coordinate is checked against the screen on its own.
			if ({1'b0, new_col} < BW1'(COLUMNS)) begin
				col_next = COL_W'(new_col);
			end
			if ({1'b0, new_row} < BW1'(ROWS)) begin
				row_next = ROW_W'(new_row);
			end
		end else if (char_code == CH_NEWLINE) begin
			res.op        = OP_FILL;
			res.row       = ROW_OUT_W'(row);
			res.col_first = COL_OUT_W'(col);
			res.col_last  = COL_OUT_W'(COLUMNS - 1);
			res.cell_res  = {attr, CH_SPACE};
			col_next      = '0;
			row_next      = row_inc;
		end else if (char_code == CH_TAB) begin
			if (tab_col >= CW1'(COLUMNS)) begin
				col_next = '0;
				row_next = row_inc;
			end else begin
				col_next = COL_W'(tab_col);
			end
		end else if (printable) begin
			res.op        = OP_CELL;
			res.row       = ROW_OUT_W'(row);
			res.col_first = COL_OUT_W'(col);
			res.col_last  = COL_OUT_W'(col);
			res.cell_res  = {attr, char_code};
			if (col_inc >= CW1'(COLUMNS)) begin
				col_next = '0;
				row_next = row_inc;
			end else begin
				col_next = COL_W'(col_inc);
			end
		end

		res.cursor_col = COL_OUT_W'(col_next);
		res.cursor_row = ROW_OUT_W'(row_next);
	end

endmodule

// ===== rtl/text_console_cursor_writer.sv =====
// ----------------------------------------------------------------------------
// Text console cursor writer
// Turns a stream of characters and cursor moves into cell writes and fills.
// ----------------------------------------------------------------------------
// An item is held in the input register, and its result in the result register, from which it is offered.
// Throughput: one item per cycle unless m_tready stalls the output; the cursor update
// is a single registered step between the input register and the result register.
// Reset: clears the cursor to column 0 of row 0 and empties both registers.
// The cursor is updated when an item moves from the input to the result stage.
module text_console_cursor_writer #(
	parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// char_code [7:0], attr [15:8], new_col [23:16], new_row [31:24]
	input  logic [31:0] s_tdata,
	// cmd [0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// row [4:0], col_first [11:5], col_last [18:12], cell_res [34:19],
	// cursor_col [41:35], cursor_row [46:42], zero [47]
	output logic [47:0] m_tdata,
	// op [1:0]
	output logic [1:0]  m_tuser
);
	import tcc_pkg::*;

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic              valid_s1;
	logic              cmd_s1;
	logic [BYTE_W-1:0] char_s1;
	logic [BYTE_W-1:0] attr_s1;
	logic [BYTE_W-1:0] ncol_s1;
	logic [BYTE_W-1:0] nrow_s1;

	logic              valid_s2;
	result_t           res_s2;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;
	result_t           res;

	logic              adv_s1;
	logic              take;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				col_q    <= col_next;
				row_q    <= row_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= s_tuser[0];
			char_s1 <= s_tdata[7:0];
			attr_s1 <= s_tdata[15:8];
			ncol_s1 <= s_tdata[23:16];
			nrow_s1 <= s_tdata[31:24];
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	tcc_step #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.COL_W   (COL_W),
		.ROW_W   (ROW_W)
	) u_step (
		.cmd       (cmd_s1),
		.char_code (char_s1),
		.attr      (attr_s1),
		.new_col   (ncol_s1),
		.new_row   (nrow_s1),
		.col       (col_q),
		.row       (row_q),
		.col_next  (col_next),
		.row_next  (row_next),
		.res       (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.op;
	assign m_tdata  = {1'b0, res_s2.cursor_row, res_s2.cursor_col, res_s2.cell_res,
		res_s2.col_last, res_s2.col_first, res_s2.row};

`ifndef SYNTH
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < (COL_W + 1)'(COLUMNS))
		else $error("cursor column beyond the screen width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < (ROW_W + 1)'(ROWS))
		else $error("cursor row beyond the screen height");

	a_none_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.op == OP_NONE) |->
		(res_s2.cell_res == '0 && res_s2.row == '0 && res_s2.col_first == '0))
		else $error("result without a write carries write fields");

	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.op == OP_FILL) |->
		(res_s2.col_last == COL_OUT_W'(COLUMNS - 1) && res_s2.cursor_col == '0))
		else $error("newline fill does not end at the last column");

	a_cursor_held: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(col_q) && $stable(row_q)))
		else $error("cursor moved without an item advancing");
`endif

endmodule
